### design/token_and_polling_link_controller_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the token and polling link controller
// Shared property forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TOKEN_AND_POLLING_LINK_CONTROLLER_CORE_ASSERT_SVH
`define TOKEN_AND_POLLING_LINK_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPLC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TPLC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/tplc_pkg.sv
// ----------------------------------------------------------------------------
// tplc_pkg
// Types, codes and helper functions of the token and polling link controller.
// ----------------------------------------------------------------------------
package tplc_pkg;

	localparam int MODE_W     = 4;
	localparam int ADDR_W     = 3;
	localparam int MAP_W      = 8;
	localparam int KIND_W     = 2;
	localparam int ROLE_W     = 2;
	localparam int PSTATE_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 3;
	localparam int MAX_CMDS   = 3;
	localparam int CNT_W      = 2;

	// Nodes on the link; addresses and the buffer map only reach eight.
	localparam int NODE_COUNT = 8;
	localparam int NODES_USED = (NODE_COUNT > 8) ? 8 : NODE_COUNT;
	localparam logic [ADDR_W:0] NODES_LIM = (ADDR_W + 1)'(NODES_USED);

	// Receive outcomes
	localparam logic [MODE_W-1:0] MODE_TIMEOUT   = 4'd0;
	localparam logic [MODE_W-1:0] MODE_USER      = 4'd1;
	localparam logic [MODE_W-1:0] MODE_POLL      = 4'd2;
	localparam logic [MODE_W-1:0] MODE_TOKEN     = 4'd3;
	localparam logic [MODE_W-1:0] MODE_ERR_FIRST = 4'd4;
	localparam logic [MODE_W-1:0] MODE_LAST      = 4'd15;

	// Frame kinds
	localparam logic [KIND_W-1:0] KIND_USER  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TOKEN = 2'd1;
	localparam logic [KIND_W-1:0] KIND_POLL  = 2'd2;

	// Node roles
	localparam logic [ROLE_W-1:0] ROLE_NONE   = 2'd0;
	localparam logic [ROLE_W-1:0] ROLE_MASTER = 2'd1;
	localparam logic [ROLE_W-1:0] ROLE_TOKEN  = 2'd2;

	// Reported protocol state codes
	localparam logic [PSTATE_W-1:0] PSTATE_WAIT = 2'd0;
	localparam logic [PSTATE_W-1:0] PSTATE_SEND = 2'd1;
	localparam logic [PSTATE_W-1:0] PSTATE_POLL = 2'd2;
	localparam logic [PSTATE_W-1:0] PSTATE_HOLD = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDRESS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MASTER_ADDRESS = 2'd2;

	typedef enum logic [3:0] {
		ST_WAIT = 4'b0001,
		ST_SEND = 4'b0010,
		ST_POLL = 4'b0100,
		ST_HOLD = 4'b1000
	} tplc_state_t;

	typedef struct packed {
		logic              protocol_mode;
		logic [ADDR_W-1:0] own_address;
		logic [ADDR_W-1:0] master_address;
	} tplc_cfg_t;

	typedef struct packed {
		logic [ADDR_W-1:0] buffer;
		logic [ADDR_W-1:0] dest;
		logic              from_buf;
		logic              own_src;
		logic [KIND_W-1:0] kind;
	} tplc_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0]             n_cmd;
		tplc_cmd_t [MAX_CMDS-1:0]     cmd;
		logic [ROLE_W-1:0]            role;
		logic [PSTATE_W-1:0]          pstate;
		logic                         err;
	} tplc_rec_t;

	typedef struct packed {
		logic                send_valid;
		tplc_cmd_t           cmd;
		logic [ROLE_W-1:0]   role;
		logic [PSTATE_W-1:0] pstate;
		logic                err;
		logic                last;
	} tplc_word_t;

	function automatic tplc_cmd_t tplc_make_cmd(input logic [ADDR_W-1:0] buffer,
		input logic [ADDR_W-1:0] dest, input logic from_buf, input logic own_src,
		input logic [KIND_W-1:0] kind);
		tplc_cmd_t c;
		c.buffer   = buffer;
		c.dest     = dest;
		c.from_buf = from_buf;
		c.own_src  = own_src;
		c.kind     = kind;
		return c;
	endfunction

	function automatic logic [PSTATE_W-1:0] tplc_encode_state(input tplc_state_t s);
		logic [PSTATE_W-1:0] code;
		case (s)
			ST_WAIT: code = PSTATE_WAIT;
			ST_SEND: code = PSTATE_SEND;
			ST_POLL: code = PSTATE_POLL;
			ST_HOLD: code = PSTATE_HOLD;
			default: code = PSTATE_WAIT;
		endcase
		return code;
	endfunction

	// Lowest full buffer: {found, index}
	function automatic logic [ADDR_W:0] tplc_lowest_full(input logic [MAP_W-1:0] map);
		logic              found;
		logic [ADDR_W-1:0] idx;
		found = 1'b0;
		idx   = '0;
		for (int b = NODES_USED - 1; b >= 0; b--) begin
			if (map[b]) begin
				found = 1'b1;
				idx   = ADDR_W'(b);
			end
		end
		return {found, idx};
	endfunction

	function automatic logic [ADDR_W-1:0] tplc_step_node(input logic [ADDR_W-1:0] c);
		logic [ADDR_W:0] inc;
		inc = {1'b0, c} + 1'b1;
		return (inc >= NODES_LIM) ? '0 : inc[ADDR_W-1:0];
	endfunction

	// Next node after the cursor, skipping this node's own address
	function automatic logic [ADDR_W-1:0] tplc_next_node(input logic [ADDR_W-1:0] c,
		input logic [ADDR_W-1:0] own);
		logic [ADDR_W-1:0] n1;
		n1 = tplc_step_node(c);
		return (n1 == own) ? tplc_step_node(n1) : n1;
	endfunction

endpackage

### design/tplc_intf.sv
// ----------------------------------------------------------------------------
// tplc channel interfaces
// Receive outcome, transmit command and configuration write channels.
// ----------------------------------------------------------------------------
interface tplc_evt_if import tplc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [ADDR_W-1:0] sender_address;
	logic [MAP_W-1:0]  pending_map;

	modport source(output valid, mode, sender_address, pending_map, input ready);
	modport sink(input valid, mode, sender_address, pending_map, output ready);
endinterface

interface tplc_res_if import tplc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                send_valid;
	logic [ADDR_W-1:0]   send_buffer;
	logic [ADDR_W-1:0]   send_dest;
	logic                dest_from_buffer;
	logic                set_own_source;
	logic [KIND_W-1:0]   frame_kind;
	logic [ROLE_W-1:0]   node_role;
	logic [PSTATE_W-1:0] protocol_state;
	logic                error_flag;
	logic                last;

	modport source(output valid, send_valid, send_buffer, send_dest, dest_from_buffer,
		set_own_source, frame_kind, node_role, protocol_state, error_flag, last,
		input ready);
	modport sink(input valid, send_valid, send_buffer, send_dest, dest_from_buffer,
		set_own_source, frame_kind, node_role, protocol_state, error_flag, last,
		output ready);
endinterface

interface tplc_cfg_if import tplc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### design/token_and_polling_link_controller_core.sv
// ----------------------------------------------------------------------------
// token_and_polling_link_controller_core
// Link-layer controller for one node, in master-slave polling or token passing.
//
// Each word on evt is the outcome of one receive attempt (timeout, user
// message, poll, token or an error kind) with the sender address and the map
// of buffers that hold outgoing messages. The front stage takes a word in the
// cycle it arrives while the queue has room, runs the whole protocol step
// at once (state, role and round-robin cursor) and pushes one record into a
// short queue; it keeps taking a word per cycle as long as the queue has room
// (QUEUE_DEPTH records). The back stage turns each record into one to three
// words on res: one per transmit command, or a single status word with
// send_valid low when nothing is sent; last marks the final word of an
// outcome, and role, state and error flag repeat on every word of it. The
// back stage issues one word per cycle through its output register while res
// is ready; an outcome has one to three result words, the token hand-back
// with own traffic being the longest, and the emitter is what sets the
// sustained rate. The first result word of an outcome passes through the queue
// and then the output register before it is on res. Write configuration on
// cfg only while idle: index 0 protocol mode, 1 own address, 2 master
// address; cfg is always ready and other indexes are ignored.
// ----------------------------------------------------------------------------
`include "token_and_polling_link_controller_core_assert.svh"

module token_and_polling_link_controller_core import tplc_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	tplc_cfg_if.sink   cfg,
	tplc_evt_if.sink   evt,
	tplc_res_if.source res
);

	tplc_cfg_t cfg_q;

	tplc_rec_t push_rec;
	tplc_rec_t head_rec;
	logic      q_push;
	logic      q_pop;
	logic      q_full;
	logic      q_empty;

	// Configuration: take every write, decode the register index
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_PROTOCOL_MODE:  cfg_q.protocol_mode  <= cfg.data[0];
				REG_OWN_ADDRESS:    cfg_q.own_address    <= cfg.data[ADDR_W-1:0];
				REG_MASTER_ADDRESS: cfg_q.master_address <= cfg.data[ADDR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Front: classify the outcome and advance the protocol state
	tplc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.evt    (evt),
		.full   (q_full),
		.push   (q_push),
		.rec    (push_rec)
	);

	// Hold step records until the back stage has drained the previous ones
	tplc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (push_rec),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (head_rec),
		.empty  (q_empty)
	);

	// Back: issue the transmit words of the head record
	tplc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head_rec),
		.empty  (q_empty),
		.pop    (q_pop),
		.res    (res)
	);

	`TPLC_ASSERT_IMP(a_no_overflow, clk, arst_n, q_push, !q_full, "record pushed into full queue")
	`TPLC_ASSERT_IMP(a_rest_state, clk, arst_n, res.valid, (res.protocol_state == PSTATE_WAIT) || (res.protocol_state == PSTATE_HOLD), "result shows a transient state")
	`TPLC_ASSERT_IMP(a_status_last, clk, arst_n, res.valid && !res.send_valid, res.last, "status word not marked last")
	`TPLC_ASSERT_NXT(a_pop_last, clk, arst_n, q_pop, res.valid && res.last, "record retired without a last word")

endmodule

### design/tplc_front.sv
// ----------------------------------------------------------------------------
// tplc_front
// Accepts receive outcomes, runs the protocol step and queues the commands.
// ----------------------------------------------------------------------------
module tplc_front import tplc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  tplc_cfg_t   cfg,
	tplc_evt_if.sink    evt,
	input  logic        full,
	output logic        push,
	output tplc_rec_t   rec
);

	tplc_state_t       ctl_q;
	logic [ROLE_W-1:0] role_q;
	logic [ADDR_W-1:0] cursor_q;

	tplc_state_t              st;
	logic [ROLE_W-1:0]        rl;
	logic [ADDR_W-1:0]        cur;
	logic                     err;
	logic                     tok;
	logic [CNT_W-1:0]         n;
	tplc_cmd_t [MAX_CMDS-1:0] cmds;
	logic [ADDR_W:0]          low;

	assign evt.ready = !full;
	assign push      = evt.valid && !full;

	always_comb begin
		st   = ctl_q;
		rl   = role_q;
		cur  = cursor_q;
		tok  = cfg.protocol_mode;
		n    = '0;
		cmds = '0;
		err  = evt.mode inside {MODE_TIMEOUT, [MODE_ERR_FIRST:MODE_LAST]};
		low  = tplc_lowest_full(evt.pending_map);

		// Classify the outcome against the waiting states
		case (ctl_q)
			ST_WAIT: begin
				if (tok) begin
					if (evt.mode == MODE_TIMEOUT) begin
						rl = ROLE_TOKEN;
						st = ST_SEND;
					end else if (evt.mode == MODE_TOKEN) begin
						cmds[n] = tplc_make_cmd(cfg.own_address, evt.sender_address,
							1'b0, 1'b1, KIND_TOKEN);
						n  = n + 1'b1;
						rl = ROLE_TOKEN;
						st = ST_SEND;
					end else if (evt.mode == MODE_POLL) begin
						err = 1'b1;
					end
				end else begin
					if (evt.mode == MODE_TIMEOUT) begin
						rl  = ROLE_MASTER;
						st  = ST_POLL;
						cur = cfg.own_address;
					end else if (evt.mode == MODE_USER || evt.mode == MODE_POLL) begin
						st = ST_SEND;
					end else if (evt.mode == MODE_TOKEN) begin
						err = 1'b1;
					end
				end
			end
			ST_HOLD: begin
				if (tok) begin
					if (evt.mode == MODE_TIMEOUT) begin
						st = ST_POLL;
					end else begin
						if (evt.mode != MODE_TOKEN) begin
							err = 1'b1;
						end
						st = ST_WAIT;
						rl = ROLE_NONE;
					end
				end else begin
					if (evt.mode == MODE_TOKEN) begin
						err = 1'b1;
					end
					st = ST_POLL;
				end
			end
			default: begin
			end
		endcase

		// Send own traffic
		if (st == ST_SEND) begin
			if (tok) begin
				if (low[ADDR_W]) begin
					cmds[n] = tplc_make_cmd(low[ADDR_W-1:0], '0, 1'b1, 1'b0, KIND_USER);
					n = n + 1'b1;
				end
				cur = cfg.own_address;
				st  = ST_POLL;
			end else begin
				if (low[ADDR_W]) begin
					cmds[n] = tplc_make_cmd(low[ADDR_W-1:0], cfg.master_address,
						1'b0, 1'b0, KIND_USER);
				end else begin
					cmds[n] = tplc_make_cmd(cfg.master_address, cfg.master_address,
						1'b0, 1'b1, KIND_POLL);
				end
				n  = n + 1'b1;
				st = ST_WAIT;
			end
		end

		// Address the next node
		if (st == ST_POLL) begin
			cur = tplc_next_node(cur, cfg.own_address);
			if (tok) begin
				cmds[n] = tplc_make_cmd(cur, cur, 1'b0, 1'b1, KIND_TOKEN);
			end else if (evt.pending_map[cur]) begin
				cmds[n] = tplc_make_cmd(cur, cur, 1'b0, 1'b0, KIND_USER);
			end else begin
				cmds[n] = tplc_make_cmd(cur, cur, 1'b0, 1'b1, KIND_POLL);
			end
			n  = n + 1'b1;
			st = ST_HOLD;
		end

		rec.n_cmd  = n;
		rec.cmd    = cmds;
		rec.role   = rl;
		rec.pstate = tplc_encode_state(st);
		rec.err    = err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q    <= ST_WAIT;
			role_q   <= ROLE_NONE;
			cursor_q <= '0;
		end else if (push) begin
			ctl_q    <= st;
			role_q   <= rl;
			cursor_q <= cur;
		end
	end

endmodule

### design/tplc_fifo.sv
// ----------------------------------------------------------------------------
// tplc_fifo
// Short queue of step records between the front and the back.
// ----------------------------------------------------------------------------
module tplc_fifo import tplc_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  tplc_rec_t wdata,
	output logic      full,
	input  logic      pop,
	output tplc_rec_t rdata,
	output logic      empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	tplc_rec_t       mem_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;

	assign full  = (cnt_q == CNT_FULL);
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### design/tplc_back.sv
// ----------------------------------------------------------------------------
// tplc_back
// Walks the queued record and issues one transmit word per cycle while res is ready.
// ----------------------------------------------------------------------------
module tplc_back import tplc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  tplc_rec_t  head,
	input  logic       empty,
	output logic       pop,
	tplc_res_if.source res
);

	logic [CNT_W-1:0] idx_q;
	logic             valid_q;
	tplc_word_t       word_q;

	logic load;
	logic last_w;

	assign load   = !valid_q || res.ready;
	assign last_w = (head.n_cmd == '0) || (idx_q == head.n_cmd - 1'b1);
	assign pop    = load && !empty && last_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= !empty;
			if (!empty) begin
				idx_q <= last_w ? '0 : idx_q + 1'b1;
			end
		end
	end

	// An empty record still gives one status word with zeroed command fields
	always_ff @(posedge clk) begin
		if (load && !empty) begin
			word_q.send_valid <= (head.n_cmd != '0);
			word_q.cmd        <= head.cmd[idx_q];
			word_q.role       <= head.role;
			word_q.pstate     <= head.pstate;
			word_q.err        <= head.err;
			word_q.last       <= last_w;
		end
	end

	assign res.valid            = valid_q;
	assign res.send_valid       = word_q.send_valid;
	assign res.send_buffer      = word_q.cmd.buffer;
	assign res.send_dest        = word_q.cmd.dest;
	assign res.dest_from_buffer = word_q.cmd.from_buf;
	assign res.set_own_source   = word_q.cmd.own_src;
	assign res.frame_kind       = word_q.cmd.kind;
	assign res.node_role        = word_q.role;
	assign res.protocol_state   = word_q.pstate;
	assign res.error_flag       = word_q.err;
	assign res.last             = word_q.last;

endmodule

### tb/token_and_polling_link_controller_core_tb.sv
// ----------------------------------------------------------------------------
// token_and_polling_link_controller_core_tb
// Self-checking bench for the link controller: receive outcomes go in on evt,
// a cycle-free model of the polling and token protocols predicts the transmit
// words, and every word taken from res is compared against the oldest
// prediction. Directed sequences walk both protocols, then random traffic runs
// under several register settings with random gaps and back-pressure.
// ----------------------------------------------------------------------------
module token_and_polling_link_controller_core_tb;
	import tplc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam time CLK_PERIOD     = 8ns;
	localparam int  RESET_CYCLES   = 10;
	localparam int  SETTLE_CYCLES  = 8;
	localparam int  WATCHDOG_LIMIT = 1000;
	localparam int  REPORT_LIMIT   = 10;
	localparam int  PHASE_ITEMS    = 28;
	localparam int  FINAL_ITEMS    = 20;

	// Outcome codes the package leaves unnamed
	localparam logic [MODE_W-1:0]    MODE_ERR_LAST = 4'd13;
	localparam logic [MODE_W-1:0]    MODE_OTHER    = 4'd14;
	// Index with no register behind it; the block must ignore it
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = 2'd3;

	logic clk = 1'b0;
	logic arst_n;

	tplc_cfg_if cfg_if ();
	tplc_evt_if evt_if ();
	tplc_res_if res_if ();

	token_and_polling_link_controller_core u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_if),
		.evt   (evt_if),
		.res   (res_if)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Shadow of the configuration registers
	logic              token_mode;
	logic [ADDR_W-1:0] own_addr;
	logic [ADDR_W-1:0] master_addr;

	// Shadow of the protocol state: control state, role, round-robin cursor
	logic [PSTATE_W-1:0] link_state;
	logic [ROLE_W-1:0]   link_role;
	logic [ADDR_W-1:0]   rr_cursor;

	// Transmit words predicted but not yet seen on res
	tplc_word_t expected_words[$];

	// Idle controls: sender gaps, receiver stalls
	bit gaps_on;
	bit stalls_on;
	int stall_left;

	int error_total;
	int outcomes_sent;
	int directed_count;
	int words_checked;
	int settings_applied;
	int quiet_cycles;

	// ------------------------------------------------------------------------
	// Protocol prediction: one receive outcome in, one to three words queued.
	// Runs the receive-driven states first, then falls through the states
	// that only transmit, until the block parks in a waiting state.
	// ------------------------------------------------------------------------
	function automatic void predict_outcome(input logic [MODE_W-1:0] m,
		input logic [ADDR_W-1:0] snd, input logic [MAP_W-1:0] map);
		tplc_cmd_t  cmds[$];
		tplc_word_t w;
		logic       err;
		int         full;

		err  = (m == MODE_TIMEOUT) || (m >= MODE_ERR_FIRST);
		full = -1;
		// lowest full buffer among the nodes in use
		for (int b = NODES_USED - 1; b >= 0; b--)
			if (map[b])
				full = b;

		if (link_state == PSTATE_WAIT) begin
			if (token_mode) begin
				if (m == MODE_TIMEOUT) begin
					// lost token: regenerate it here
					link_role  = ROLE_TOKEN;
					link_state = PSTATE_SEND;
				end else if (m == MODE_TOKEN) begin
					// acknowledge the token back to whoever passed it
					cmds.push_back(tplc_cmd_t'{buffer: own_addr, dest: snd, from_buf: 1'b0,
						own_src: 1'b1, kind: KIND_TOKEN});
					link_role  = ROLE_TOKEN;
					link_state = PSTATE_SEND;
				end else if (m == MODE_POLL) begin
					err = 1'b1;
				end
			end else begin
				if (m == MODE_TIMEOUT) begin
					// nobody polled us: take over as master
					link_role  = ROLE_MASTER;
					link_state = PSTATE_POLL;
					rr_cursor  = own_addr;
				end else if (m == MODE_USER || m == MODE_POLL) begin
					link_state = PSTATE_SEND;
				end else if (m == MODE_TOKEN) begin
					err = 1'b1;
				end
			end
		end else if (link_state == PSTATE_HOLD) begin
			if (token_mode) begin
				if (m == MODE_TIMEOUT) begin
					link_state = PSTATE_POLL;
				end else begin
					// token went on or something broke: drop the hold
					if (m != MODE_TOKEN)
						err = 1'b1;
					link_state = PSTATE_WAIT;
					link_role  = ROLE_NONE;
				end
			end else begin
				if (m == MODE_TOKEN)
					err = 1'b1;
				link_state = PSTATE_POLL;
			end
		end

		if (link_state == PSTATE_SEND) begin
			if (token_mode) begin
				if (full >= 0)
					cmds.push_back(tplc_cmd_t'{buffer: ADDR_W'(full), dest: '0, from_buf: 1'b1,
						own_src: 1'b0, kind: KIND_USER});
				rr_cursor  = own_addr;
				link_state = PSTATE_POLL;
			end else begin
				if (full >= 0)
					cmds.push_back(tplc_cmd_t'{buffer: ADDR_W'(full), dest: master_addr,
						from_buf: 1'b0, own_src: 1'b0, kind: KIND_USER});
				else
					cmds.push_back(tplc_cmd_t'{buffer: master_addr, dest: master_addr,
						from_buf: 1'b0, own_src: 1'b1, kind: KIND_POLL});
				link_state = PSTATE_WAIT;
			end
		end

		if (link_state == PSTATE_POLL) begin
			// advance round-robin, never landing on ourselves
			do begin
				rr_cursor = (int'(rr_cursor) + 1 >= NODES_USED) ? '0 : rr_cursor + 1'b1;
			end while (rr_cursor == own_addr);
			if (token_mode)
				cmds.push_back(tplc_cmd_t'{buffer: rr_cursor, dest: rr_cursor, from_buf: 1'b0,
					own_src: 1'b1, kind: KIND_TOKEN});
			else if (map[rr_cursor])
				cmds.push_back(tplc_cmd_t'{buffer: rr_cursor, dest: rr_cursor, from_buf: 1'b0,
					own_src: 1'b0, kind: KIND_USER});
			else
				cmds.push_back(tplc_cmd_t'{buffer: rr_cursor, dest: rr_cursor, from_buf: 1'b0,
					own_src: 1'b1, kind: KIND_POLL});
			link_state = PSTATE_HOLD;
		end

		// nothing sent: a lone status word
		if (cmds.size() == 0) begin
			w            = '0;
			w.role       = link_role;
			w.pstate     = link_state;
			w.err        = err;
			w.last       = 1'b1;
			expected_words.push_back(w);
		end else begin
			foreach (cmds[k]) begin
				w.send_valid = 1'b1;
				w.cmd        = cmds[k];
				w.role       = link_role;
				w.pstate     = link_state;
				w.err        = err;
				w.last       = (k == cmds.size() - 1);
				expected_words.push_back(w);
			end
		end
	endfunction

	function automatic string word_text(input tplc_word_t w);
		return $sformatf("sv=%0d buf=%0d dest=%0d fb=%0d os=%0d kind=%0d role=%0d st=%0d err=%0d last=%0d",
			w.send_valid, w.cmd.buffer, w.cmd.dest, w.cmd.from_buf, w.cmd.own_src,
			w.cmd.kind, w.role, w.pstate, w.err, w.last);
	endfunction

	task automatic note_failure(input string msg);
		error_total++;
		if (error_total <= REPORT_LIMIT)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------

	// Write one register; hold valid until the handshake, then drop it.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= data;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		case (idx)
			REG_PROTOCOL_MODE:  token_mode  = data[0];
			REG_OWN_ADDRESS:    own_addr    = data;
			REG_MASTER_ADDRESS: master_addr = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic apply_setting(input logic [CFG_DATA_W-1:0] mode_data,
		input logic [ADDR_W-1:0] own, input logic [ADDR_W-1:0] master);
		write_reg(REG_PROTOCOL_MODE, mode_data);
		write_reg(REG_OWN_ADDRESS, own);
		write_reg(REG_MASTER_ADDRESS, master);
		settings_applied++;
	endtask

	// Send one outcome word; valid stays high afterwards unless a gap follows.
	task automatic send_outcome(input logic [MODE_W-1:0] m, input logic [ADDR_W-1:0] snd,
		input logic [MAP_W-1:0] map);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			evt_if.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		evt_if.valid          <= 1'b1;
		evt_if.mode           <= m;
		evt_if.sender_address <= snd;
		evt_if.pending_map    <= map;
		do @(posedge clk); while (evt_if.ready !== 1'b1);
		predict_outcome(m, snd, map);
		outcomes_sent++;
	endtask

	// Drop valid, wait for every predicted word, then let the pipe go quiet.
	task automatic settle_link();
		@(negedge clk);
		evt_if.valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Random content, weighted toward sequences each protocol expects
	// ------------------------------------------------------------------------
	function automatic logic [MODE_W-1:0] pick_mode();
		int r;
		r = $urandom_range(0, 99);
		if (r >= 93)
			return ($urandom_range(0, 1) != 0) ? MODE_LAST : MODE_OTHER;
		if (r >= 78)
			return MODE_W'($urandom_range(MODE_ERR_FIRST, MODE_ERR_LAST));
		if (token_mode) begin
			if (r < 30) return MODE_TIMEOUT;
			if (r < 35) return MODE_USER;
			if (r < 40) return MODE_POLL;
			return MODE_TOKEN;
		end
		if (r < 25) return MODE_TIMEOUT;
		if (r < 50) return MODE_USER;
		if (r < 70) return MODE_POLL;
		return MODE_TOKEN;
	endfunction

	function automatic logic [MAP_W-1:0] pick_map();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20) return '0;
		if (r < 40) return MAP_W'(1) << $urandom_range(0, MAP_W - 1);
		if (r < 50) return '1;
		return MAP_W'($urandom_range(0, 255));
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Polling: slave replies, unexpected token, error kinds, then mastership.
	task automatic test_polling_directed();
		apply_setting(3'd0, 3'd0, 3'd7);
		send_outcome(MODE_USER, 3'd7, 8'h00);       // slave, nothing queued: poll back
		send_outcome(MODE_POLL, 3'd0, 8'h80);       // slave sends top buffer to master
		send_outcome(MODE_TOKEN, 3'd3, 8'hFF);      // token while polling: error
		send_outcome(MODE_ERR_FIRST, 3'd1, 8'hFF);
		send_outcome(MODE_OTHER, 3'd2, 8'h55);
		send_outcome(MODE_LAST, 3'd4, 8'hAA);
		send_outcome(MODE_TIMEOUT, 3'd0, 8'h02);    // become master, serve node 1
		send_outcome(MODE_USER, 3'd1, 8'h00);       // poll node 2
		send_outcome(MODE_TOKEN, 3'd2, 8'h08);      // token while master: error
		send_outcome(MODE_ERR_LAST, 3'd3, 8'hFF);
		send_outcome(MODE_TIMEOUT, 3'd5, 8'h00);
		directed_count += 11;
		settle_link();
	endtask

	// Token passing: hand-back with own traffic, circulation, ending the hold.
	task automatic test_token_directed();
		apply_setting(3'd1, 3'd7, 3'd0);
		write_reg(REG_UNUSED, 3'd7);                // no register there: ignored
		send_outcome(MODE_POLL, 3'd0, 8'h00);       // drops the hold with an error
		send_outcome(MODE_POLL, 3'd6, 8'hFF);       // poll in waiting: error
		send_outcome(MODE_USER, 3'd1, 8'hFF);
		send_outcome(MODE_TOKEN, 3'd5, 8'h01);      // three words: ack, buffer, token
		send_outcome(MODE_TIMEOUT, 3'd0, 8'h00);    // token lost downstream: pass again
		send_outcome(MODE_USER, 3'd2, 8'h10);       // message while holding: error
		send_outcome(MODE_TIMEOUT, 3'd0, 8'h80);    // regenerate token
		send_outcome(MODE_TOKEN, 3'd1, 8'h00);      // token came round: release
		send_outcome(MODE_TOKEN, 3'd0, 8'h00);
		send_outcome(MODE_LAST, 3'd7, 8'hFF);
		directed_count += 10;
		settle_link();
	endtask

	// Random outcomes under a series of settings, extremes first.
	task automatic test_random_traffic();
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: apply_setting(3'd0, 3'd3, 3'd5);
				1: apply_setting(3'd1, 3'd0, 3'd7);
				2: apply_setting(3'd0, 3'd7, 3'd0);
				3: apply_setting(3'd7, 3'd4, 3'd2);
				default: apply_setting(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
					3'($urandom_range(0, 7)));
			endcase
			// alternate idle and back-to-back phases; the last one runs flat out
			gaps_on   = (phase < 5) && (phase % 2 == 0);
			stalls_on = (phase < 5) && (phase != 3);
			repeat ((phase < 5) ? PHASE_ITEMS : FINAL_ITEMS)
				send_outcome(pick_mode(), 3'($urandom_range(0, 7)), pick_map());
			settle_link();
		end
	endtask

	// ------------------------------------------------------------------------
	// Receiver: random stall bursts on ready; a burst ends when stalls are off
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (stalls_on && stall_left != 0) begin
			stall_left--;
			res_if.ready <= 1'b0;
		end else if (stalls_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 15);
			res_if.ready <= 1'b0;
		end else begin
			stall_left = 0;
			res_if.ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// Checker: compare each accepted word with the oldest prediction
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		tplc_word_t got;
		tplc_word_t want;
		if (arst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
			got.send_valid   = res_if.send_valid;
			got.cmd.buffer   = res_if.send_buffer;
			got.cmd.dest     = res_if.send_dest;
			got.cmd.from_buf = res_if.dest_from_buffer;
			got.cmd.own_src  = res_if.set_own_source;
			got.cmd.kind     = res_if.frame_kind;
			got.role         = res_if.node_role;
			got.pstate       = res_if.protocol_state;
			got.err          = res_if.error_flag;
			got.last         = res_if.last;
			words_checked++;
			if (expected_words.size() == 0) begin
				note_failure($sformatf("word with none predicted: %s", word_text(got)));
			end else begin
				want = expected_words.pop_front();
				if (got !== want)
					note_failure($sformatf("expected %s, got %s", word_text(want),
						word_text(got)));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: count cycles in which no channel moves a word
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n !== 1'b1)
			quiet_cycles = 0;
		else if ((evt_if.valid === 1'b1 && evt_if.ready === 1'b1) ||
			(res_if.valid === 1'b1 && res_if.ready === 1'b1) ||
			(cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles++;
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("[%0t] watchdog: no word moved for %0d cycles, %0d still predicted",
			$realtime, WATCHDOG_LIMIT, expected_words.size());
		$display("FAIL");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		// hold every input at a known value from time zero
		arst_n                = 1'b0;
		evt_if.valid          = 1'b0;
		evt_if.mode           = MODE_TIMEOUT;
		evt_if.sender_address = '0;
		evt_if.pending_map    = '0;
		cfg_if.valid          = 1'b0;
		cfg_if.index          = REG_PROTOCOL_MODE;
		cfg_if.data           = '0;
		res_if.ready          = 1'b0;
		stall_left            = 0;
		gaps_on               = 1'b1;
		stalls_on             = 1'b1;
		// shadow state matches the block after reset
		token_mode  = 1'b0;
		own_addr    = '0;
		master_addr = '0;
		link_state  = PSTATE_WAIT;
		link_role   = ROLE_NONE;
		rr_cursor   = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_polling_directed();
		test_token_directed();
		test_random_traffic();

		$display("Covered %0d receive outcomes (%0d directed) and %0d result words",
			outcomes_sent, directed_count, words_checked);
		$display("over %0d register settings in polling and token modes, %0d mismatches",
			settings_applied, error_total);
		if (error_total == 0 && expected_words.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+design
design/tplc_pkg.sv
design/tplc_intf.sv
design/tplc_front.sv
design/tplc_fifo.sv
design/tplc_back.sv
design/token_and_polling_link_controller_core.sv
tb/token_and_polling_link_controller_core_tb.sv
